// ===== src/nearest_triangle_hit_depth_core_defines.svh =====
// Assertion macros used by the nearest-hit depth core checker.
`ifndef NEAREST_TRIANGLE_HIT_DEPTH_CORE_DEFINES_SVH
`define NEAREST_TRIANGLE_HIT_DEPTH_CORE_DEFINES_SVH

// Property checked only while out of reset.
`define NTHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that also covers the reset cycles.
`define NTHD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/nthd_pkg.sv =====
// Shared types, constants and the multiply term table of the nearest-hit depth core.
`timescale 1ns / 1ps
`default_nettype none
package nthd_pkg;

    localparam int MAX_TRIANGLES_DEF = 1024;

    localparam int CRD_W    = 32;   // Q16.16 coordinate
    localparam int EDG_W    = 33;   // coordinate difference
    localparam int WID_W    = 67;   // cross product component
    localparam int ACC_W    = 104;  // dot product accumulator
    localparam int DIG_W    = 17;   // signed multiplier digit
    localparam int PROD_W   = WID_W + DIG_W;
    localparam int DIST_W   = 31;
    localparam int HIDX_W   = 10;
    localparam int CFG_W    = 11;
    localparam int SLOT_W   = 10;
    localparam int VSEL_W   = 2;
    localparam int TERM_W   = 5;
    localparam int NUM_TERMS = 24;
    localparam int DIG_LAST = 2;
    localparam int DIV_STEPS = 31;
    localparam int DSTEP_W  = 5;
    localparam int SHADE_SHIFT = 36;
    localparam int SHADE_W  = 27;

    localparam logic [DIST_W-1:0] DIST_SAT = 31'h7FFF_FFFF;
    // ceil(2^36 / 21): exact floor(x / 21) for any 31-bit x
    localparam logic [31:0] RECIP_21 = 32'd3272356036;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RAY  = 1'b1;

    localparam logic [VSEL_W-1:0] VSEL_A    = 2'd0;
    localparam logic [VSEL_W-1:0] VSEL_B    = 2'd1;
    localparam logic [VSEL_W-1:0] VSEL_C    = 2'd2;
    localparam logic [VSEL_W-1:0] VSEL_NONE = 2'd3;

    // wide operand select
    localparam logic [3:0] A_D0 = 4'd0;
    localparam logic [3:0] A_D1 = 4'd1;
    localparam logic [3:0] A_D2 = 4'd2;
    localparam logic [3:0] A_S0 = 4'd3;
    localparam logic [3:0] A_S1 = 4'd4;
    localparam logic [3:0] A_S2 = 4'd5;
    localparam logic [3:0] A_P0 = 4'd6;
    localparam logic [3:0] A_P1 = 4'd7;
    localparam logic [3:0] A_P2 = 4'd8;
    localparam logic [3:0] A_Q0 = 4'd9;
    localparam logic [3:0] A_Q1 = 4'd10;
    localparam logic [3:0] A_Q2 = 4'd11;

    // narrow operand select
    localparam logic [3:0] B_E10 = 4'd0;
    localparam logic [3:0] B_E11 = 4'd1;
    localparam logic [3:0] B_E12 = 4'd2;
    localparam logic [3:0] B_E20 = 4'd3;
    localparam logic [3:0] B_E21 = 4'd4;
    localparam logic [3:0] B_E22 = 4'd5;
    localparam logic [3:0] B_S0  = 4'd6;
    localparam logic [3:0] B_S1  = 4'd7;
    localparam logic [3:0] B_S2  = 4'd8;
    localparam logic [3:0] B_D0  = 4'd9;
    localparam logic [3:0] B_D1  = 4'd10;
    localparam logic [3:0] B_D2  = 4'd11;

    // accumulator destination
    localparam logic [3:0] DST_P0  = 4'd0;
    localparam logic [3:0] DST_P1  = 4'd1;
    localparam logic [3:0] DST_P2  = 4'd2;
    localparam logic [3:0] DST_Q0  = 4'd3;
    localparam logic [3:0] DST_Q1  = 4'd4;
    localparam logic [3:0] DST_Q2  = 4'd5;
    localparam logic [3:0] DST_DET = 4'd6;
    localparam logic [3:0] DST_U   = 4'd7;
    localparam logic [3:0] DST_V   = 4'd8;
    localparam logic [3:0] DST_N   = 4'd9;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } t_term;

    typedef struct packed {
        logic                ray_start;
        logic                ld_acc;
        logic                cfg_we;
        logic                rd_en;
        logic [VSEL_W-1:0]   rd_sel;
        logic                cap_en;
        logic [VSEL_W-1:0]   cap_sel;
        logic                edge_en;
        logic                mac_en;
        logic [TERM_W-1:0]   term;
        logic [1:0]          digit;
        logic                cls_en;
        logic                div_init;
        logic                div_step;
        logic                upd_en;
        logic                tri_inc;
        logic                shade_en;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic tri_done;
        logic tri_ok;
        logic div_sat;
    } t_stat;

    function automatic t_term mk_term(input logic [3:0] a, input logic [3:0] b,
                                      input logic n, input logic f, input logic l,
                                      input logic [3:0] d);
        t_term t;
        t.a_sel = a;
        t.b_sel = b;
        t.neg   = n;
        t.first = f;
        t.last  = l;
        t.dest  = d;
        return t;
    endfunction

    // p = d x e2, det = e1.p, u = s.p, q = s x e1, v = d.q, n = e2.q
    function automatic t_term term_info(input logic [TERM_W-1:0] idx);
        t_term t;
        case (idx)
            5'd0:  t = mk_term(A_D1, B_E22, 1'b0, 1'b1, 1'b0, DST_P0);
            5'd1:  t = mk_term(A_D2, B_E21, 1'b1, 1'b0, 1'b1, DST_P0);
            5'd2:  t = mk_term(A_D2, B_E20, 1'b0, 1'b1, 1'b0, DST_P1);
            5'd3:  t = mk_term(A_D0, B_E22, 1'b1, 1'b0, 1'b1, DST_P1);
            5'd4:  t = mk_term(A_D0, B_E21, 1'b0, 1'b1, 1'b0, DST_P2);
            5'd5:  t = mk_term(A_D1, B_E20, 1'b1, 1'b0, 1'b1, DST_P2);
            5'd6:  t = mk_term(A_P0, B_E10, 1'b0, 1'b1, 1'b0, DST_DET);
            5'd7:  t = mk_term(A_P1, B_E11, 1'b0, 1'b0, 1'b0, DST_DET);
            5'd8:  t = mk_term(A_P2, B_E12, 1'b0, 1'b0, 1'b1, DST_DET);
            5'd9:  t = mk_term(A_P0, B_S0,  1'b0, 1'b1, 1'b0, DST_U);
            5'd10: t = mk_term(A_P1, B_S1,  1'b0, 1'b0, 1'b0, DST_U);
            5'd11: t = mk_term(A_P2, B_S2,  1'b0, 1'b0, 1'b1, DST_U);
            5'd12: t = mk_term(A_S1, B_E12, 1'b0, 1'b1, 1'b0, DST_Q0);
            5'd13: t = mk_term(A_S2, B_E11, 1'b1, 1'b0, 1'b1, DST_Q0);
            5'd14: t = mk_term(A_S2, B_E10, 1'b0, 1'b1, 1'b0, DST_Q1);
            5'd15: t = mk_term(A_S0, B_E12, 1'b1, 1'b0, 1'b1, DST_Q1);
            5'd16: t = mk_term(A_S0, B_E11, 1'b0, 1'b1, 1'b0, DST_Q2);
            5'd17: t = mk_term(A_S1, B_E10, 1'b1, 1'b0, 1'b1, DST_Q2);
            5'd18: t = mk_term(A_Q0, B_D0,  1'b0, 1'b1, 1'b0, DST_V);
            5'd19: t = mk_term(A_Q1, B_D1,  1'b0, 1'b0, 1'b0, DST_V);
            5'd20: t = mk_term(A_Q2, B_D2,  1'b0, 1'b0, 1'b1, DST_V);
            5'd21: t = mk_term(A_Q0, B_E20, 1'b0, 1'b1, 1'b0, DST_N);
            5'd22: t = mk_term(A_Q1, B_E21, 1'b0, 1'b0, 1'b0, DST_N);
            5'd23: t = mk_term(A_Q2, B_E22, 1'b0, 1'b0, 1'b1, DST_N);
            default: t = mk_term(A_D0, B_D0, 1'b0, 1'b1, 1'b0, DST_N);
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== src/nthd_dp.sv =====
// Datapath: triangle table, multiply-accumulate unit, divider and nearest-hit tracking.
`timescale 1ns / 1ps
`default_nettype none
module nthd_dp #(
    parameter int MAX_TRIANGLES = nthd_pkg::MAX_TRIANGLES_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire nthd_pkg::t_cmd                    i_cmd,
    output nthd_pkg::t_stat                        o_stat,
    input  wire        [nthd_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire        [nthd_pkg::SLOT_W-1:0]      i_triangle_slot,
    input  wire        [nthd_pkg::VSEL_W-1:0]      i_vertex_select,
    input  wire signed [nthd_pkg::CRD_W-1:0]       i_point_x,
    input  wire signed [nthd_pkg::CRD_W-1:0]       i_point_y,
    input  wire signed [nthd_pkg::CRD_W-1:0]       i_point_z,
    input  wire signed [nthd_pkg::CRD_W-1:0]       i_dir_x,
    input  wire signed [nthd_pkg::CRD_W-1:0]       i_dir_y,
    input  wire signed [nthd_pkg::CRD_W-1:0]       i_dir_z,
    output logic                                   o_hit,
    output logic       [nthd_pkg::HIDX_W-1:0]      o_hit_index,
    output logic       [nthd_pkg::DIST_W-1:0]      o_hit_distance,
    output logic       [nthd_pkg::DIST_W-1:0]      o_depth_shade
);
    import nthd_pkg::*;

    localparam int ROWS  = MAX_TRIANGLES * 3;
    localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

    logic [3*CRD_W-1:0] mem [ROWS];
    logic [3*CRD_W-1:0] r_rd;

    logic [CFG_W-1:0] r_count;
    logic [CNT_W-1:0] r_tri;

    logic signed [CRD_W-1:0] r_org [3];
    logic signed [CRD_W-1:0] r_dir [3];
    logic signed [CRD_W-1:0] r_va [3];
    logic signed [CRD_W-1:0] r_vb [3];
    logic signed [CRD_W-1:0] r_vc [3];
    logic signed [EDG_W-1:0] r_e1 [3];
    logic signed [EDG_W-1:0] r_e2 [3];
    logic signed [EDG_W-1:0] r_s [3];
    logic signed [WID_W-1:0] r_p [3];
    logic signed [WID_W-1:0] r_q [3];
    logic signed [ACC_W-1:0] r_acc, r_det, r_u, r_v, r_n;

    logic                r_ok;
    logic [ACC_W-1:0]    r_den, r_rem;
    logic [DIST_W-1:0]   r_low, r_quot;
    logic                r_found;
    logic [DIST_W-1:0]   r_best;
    logic [CNT_W-1:0]    r_best_idx;
    logic [62:0]         r_shade_prod;

    logic [31:0] wr_addr32, rd_addr32, cnt32, cfg32;
    logic        slot_ok;

    assign wr_addr32 = {{(32-SLOT_W){1'b0}}, i_triangle_slot} * 32'd3
                     + {{(32-VSEL_W){1'b0}}, i_vertex_select};
    assign rd_addr32 = 32'(r_tri) * 32'd3 + {{(32-VSEL_W){1'b0}}, i_cmd.rd_sel};
    assign slot_ok   = {{(32-SLOT_W){1'b0}}, i_triangle_slot} < 32'(MAX_TRIANGLES);
    assign cfg32     = {{(32-CFG_W){1'b0}}, r_count};
    assign cnt32     = (cfg32 > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES) : cfg32;

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_acc && i_vertex_select != VSEL_NONE && slot_ok) begin
            mem[wr_addr32[AW-1:0]] <= {i_point_z, i_point_y, i_point_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr32[AW-1:0]];
        end
    end

    // multiply-accumulate operands
    t_term                    tm;
    logic signed [WID_W-1:0]  a_val;
    logic signed [EDG_W-1:0]  b_val;
    logic signed [DIG_W-1:0]  dig;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext, prod_sh, acc_base, acc_nx;

    assign tm = term_info(i_cmd.term);

    always_comb begin
        case (tm.a_sel)
            A_D0:    a_val = WID_W'(r_dir[0]);
            A_D1:    a_val = WID_W'(r_dir[1]);
            A_D2:    a_val = WID_W'(r_dir[2]);
            A_S0:    a_val = WID_W'(r_s[0]);
            A_S1:    a_val = WID_W'(r_s[1]);
            A_S2:    a_val = WID_W'(r_s[2]);
            A_P0:    a_val = r_p[0];
            A_P1:    a_val = r_p[1];
            A_P2:    a_val = r_p[2];
            A_Q0:    a_val = r_q[0];
            A_Q1:    a_val = r_q[1];
            A_Q2:    a_val = r_q[2];
            default: a_val = '0;
        endcase
        case (tm.b_sel)
            B_E10:   b_val = r_e1[0];
            B_E11:   b_val = r_e1[1];
            B_E12:   b_val = r_e1[2];
            B_E20:   b_val = r_e2[0];
            B_E21:   b_val = r_e2[1];
            B_E22:   b_val = r_e2[2];
            B_S0:    b_val = r_s[0];
            B_S1:    b_val = r_s[1];
            B_S2:    b_val = r_s[2];
            B_D0:    b_val = EDG_W'(r_dir[0]);
            B_D1:    b_val = EDG_W'(r_dir[1]);
            B_D2:    b_val = EDG_W'(r_dir[2]);
            default: b_val = '0;
        endcase
        // two unsigned 16-bit digits, then the sign digit
        case (i_cmd.digit)
            2'd0:    dig = {1'b0, b_val[15:0]};
            2'd1:    dig = {1'b0, b_val[31:16]};
            default: dig = {DIG_W{b_val[EDG_W-1]}};
        endcase
        prod     = a_val * dig;
        prod_ext = ACC_W'(prod);
        case (i_cmd.digit)
            2'd0:    prod_sh = prod_ext;
            2'd1:    prod_sh = prod_ext <<< 16;
            default: prod_sh = prod_ext <<< 32;
        endcase
        acc_base = (i_cmd.digit == 2'd0 && tm.first) ? '0 : r_acc;
        acc_nx   = tm.neg ? (acc_base - prod_sh) : (acc_base + prod_sh);
    end

    // hit classification
    logic                    det_neg, pos_bad, neg_bad, cls_ok;
    logic signed [ACC_W-1:0] uv, den_s, nn;
    logic [ACC_W-1:0]        rem2;
    logic                    rem_ge;

    always_comb begin
        det_neg = r_det[ACC_W-1];
        uv      = r_u + r_v;
        pos_bad = (r_u < 0) || (r_det < r_u) || (r_v < 0) || (r_det < uv);
        neg_bad = (r_u > 0) || (r_u < r_det) || (r_v > 0) || (uv < r_det);
        den_s   = det_neg ? -r_det : r_det;
        nn      = det_neg ? -r_n : r_n;
        cls_ok  = (r_det != '0) && !(det_neg ? neg_bad : pos_bad) && !nn[ACC_W-1];
        rem2    = {r_rem[ACC_W-2:0], r_low[DIST_W-1]};
        rem_ge  = rem2 >= r_den;
    end

    assign o_stat.tri_done = (32'(r_tri) == cnt32);
    assign o_stat.tri_ok   = r_ok;
    assign o_stat.div_sat  = r_rem >= r_den;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ray_start) begin
            r_org[0] <= i_point_x;
            r_org[1] <= i_point_y;
            r_org[2] <= i_point_z;
            r_dir[0] <= i_dir_x;
            r_dir[1] <= i_dir_y;
            r_dir[2] <= i_dir_z;
            r_best   <= '0;
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                VSEL_A: begin
                    r_va[0] <= r_rd[31:0];
                    r_va[1] <= r_rd[63:32];
                    r_va[2] <= r_rd[95:64];
                end
                VSEL_B: begin
                    r_vb[0] <= r_rd[31:0];
                    r_vb[1] <= r_rd[63:32];
                    r_vb[2] <= r_rd[95:64];
                end
                default: begin
                    r_vc[0] <= r_rd[31:0];
                    r_vc[1] <= r_rd[63:32];
                    r_vc[2] <= r_rd[95:64];
                end
            endcase
        end
        if (i_cmd.edge_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EDG_W'(r_vb[k]) - EDG_W'(r_va[k]);
                r_e2[k] <= EDG_W'(r_vc[k]) - EDG_W'(r_va[k]);
                r_s[k]  <= EDG_W'(r_org[k]) - EDG_W'(r_va[k]);
            end
        end
        if (i_cmd.mac_en) begin
            r_acc <= acc_nx;
            if (i_cmd.digit == 2'(DIG_LAST) && tm.last) begin
                case (tm.dest)
                    DST_P0:  r_p[0] <= acc_nx[WID_W-1:0];
                    DST_P1:  r_p[1] <= acc_nx[WID_W-1:0];
                    DST_P2:  r_p[2] <= acc_nx[WID_W-1:0];
                    DST_Q0:  r_q[0] <= acc_nx[WID_W-1:0];
                    DST_Q1:  r_q[1] <= acc_nx[WID_W-1:0];
                    DST_Q2:  r_q[2] <= acc_nx[WID_W-1:0];
                    DST_DET: r_det  <= acc_nx;
                    DST_U:   r_u    <= acc_nx;
                    DST_V:   r_v    <= acc_nx;
                    default: r_n    <= acc_nx;
                endcase
            end
        end
        if (i_cmd.cls_en) begin
            r_ok  <= cls_ok;
            r_den <= den_s;
            r_rem <= {15'd0, nn[ACC_W-1:15]};
            r_low <= {nn[14:0], 16'd0};
        end
        if (i_cmd.div_init) begin
            r_quot <= o_stat.div_sat ? DIST_SAT : '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? (rem2 - r_den) : rem2;
            r_low  <= {r_low[DIST_W-2:0], 1'b0};
            r_quot <= {r_quot[DIST_W-2:0], rem_ge};
        end
        if (i_cmd.upd_en && r_ok && (!r_found || r_quot < r_best)) begin
            r_best <= r_quot;
        end
        if (i_cmd.shade_en) begin
            r_shade_prod <= 63'(r_best) * 63'(RECIP_21);
        end
        if (i_cmd.out_load) begin
            o_hit_distance <= r_best;
            o_depth_shade  <= {{(DIST_W-SHADE_W){1'b0}}, r_shade_prod[62:SHADE_SHIFT]};
        end
    end

    // control registers
    logic [31:0] best_idx32;
    assign best_idx32 = 32'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_tri      <= '0;
            r_found    <= 1'b0;
            r_best_idx <= '0;
            o_hit      <= 1'b0;
            o_hit_index <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (i_cmd.ray_start) begin
                r_tri      <= '0;
                r_found    <= 1'b0;
                r_best_idx <= '0;
            end else if (i_cmd.tri_inc) begin
                r_tri <= r_tri + 1'b1;
            end
            if (i_cmd.upd_en && r_ok && (!r_found || r_quot < r_best)) begin
                r_found    <= 1'b1;
                r_best_idx <= r_tri;
            end
            if (i_cmd.out_load) begin
                o_hit       <= r_found;
                o_hit_index <= best_idx32[HIDX_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/nthd_ctrl.sv =====
// Controller: sequences fetch, multiply terms and division per triangle, and the result hand-off per ray.
`timescale 1ns / 1ps
`default_nettype none
module nthd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire                  i_req_type,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output nthd_pkg::t_cmd       o_cmd,
    input  wire nthd_pkg::t_stat i_stat
);
    import nthd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_F0    = 4'd2;
    localparam logic [3:0] S_F1    = 4'd3;
    localparam logic [3:0] S_F2    = 4'd4;
    localparam logic [3:0] S_F3    = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_MAC   = 4'd7;
    localparam logic [3:0] S_CLS   = 4'd8;
    localparam logic [3:0] S_DCHK  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_UPD   = 4'd11;
    localparam logic [3:0] S_SHADE = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]         r_state, n_state;
    logic [TERM_W-1:0]  r_term, n_term;
    logic [1:0]         r_dig, n_dig;
    logic [DSTEP_W-1:0] r_dstep, n_dstep;
    logic               r_out_valid, n_out_valid;
    logic               in_acc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_dig       = r_dig;
        n_dstep     = r_dstep;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.cfg_we = i_cfg_valid;
        o_cmd.term   = r_term;
        o_cmd.digit  = r_dig;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_RAY) begin
                        o_cmd.ray_start = 1'b1;
                        n_state = S_CHK;
                    end else begin
                        o_cmd.ld_acc = 1'b1;
                    end
                end
            end
            S_CHK: begin
                n_state = i_stat.tri_done ? S_SHADE : S_F0;
            end
            S_F0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = VSEL_A;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = VSEL_B;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = VSEL_A;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = VSEL_C;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = VSEL_B;
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = VSEL_C;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                o_cmd.edge_en = 1'b1;
                n_term  = '0;
                n_dig   = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_en = 1'b1;
                if (r_dig == 2'(DIG_LAST)) begin
                    n_dig = '0;
                    if (r_term == TERM_W'(NUM_TERMS - 1)) begin
                        n_term  = '0;
                        n_state = S_CLS;
                    end else begin
                        n_term = r_term + 1'b1;
                    end
                end else begin
                    n_dig = r_dig + 1'b1;
                end
            end
            S_CLS: begin
                o_cmd.cls_en = 1'b1;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                o_cmd.div_init = 1'b1;
                n_dstep = '0;
                // saturated or missed: skip the divide
                n_state = (!i_stat.tri_ok || i_stat.div_sat) ? S_UPD : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_dstep == DSTEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_UPD;
                end else begin
                    n_dstep = r_dstep + 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.upd_en  = 1'b1;
                o_cmd.tri_inc = 1'b1;
                n_state = S_CHK;
            end
            S_SHADE: begin
                o_cmd.shade_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the previous result transaction is gone
                if (!r_out_valid) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_term      <= '0;
            r_dig       <= '0;
            r_dstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_dig       <= n_dig;
            r_dstep     <= n_dstep;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== src/nearest_triangle_hit_depth_core.sv =====
// Nearest-hit depth core: triangle table and closest-hit ray test, top level.
// Input channel (i_in_valid / o_in_stall): a transaction with i_req_type 0 writes
// one vertex (a, b or c by i_vertex_select) of table slot i_triangle_slot;
// with i_req_type 1 it casts a ray from i_point_* along i_dir_*.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): sets the number of
// triangles tested per ray; write it only while the core is idle.
// Output channel (o_out_valid / i_out_stall): one transaction per ray with hit,
// index, Q16.16 distance and distance/21; a miss gives zeros.
// Each ray walks the table one triangle at a time through a shared
// 67x17 multiply-accumulate unit (24 products in 3 digits each) and a 1-bit
// per cycle restoring divider that a missed or saturated triangle skips.
// The input stalls while a ray is in flight; loads do not stall it.
// A finished result waits in the output register while a stall is held, and the
// next ray is accepted and computed meanwhile; it hands off once the register empties.
// Synchronous reset clears the triangle count and the output valid; the table
// contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module nearest_triangle_hit_depth_core #(
    parameter int MAX_TRIANGLES = nthd_pkg::MAX_TRIANGLES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_req_type,
    input  wire        [nthd_pkg::SLOT_W-1:0]  i_triangle_slot,
    input  wire        [nthd_pkg::VSEL_W-1:0]  i_vertex_select,
    input  wire signed [nthd_pkg::CRD_W-1:0]   i_point_x,
    input  wire signed [nthd_pkg::CRD_W-1:0]   i_point_y,
    input  wire signed [nthd_pkg::CRD_W-1:0]   i_point_z,
    input  wire signed [nthd_pkg::CRD_W-1:0]   i_dir_x,
    input  wire signed [nthd_pkg::CRD_W-1:0]   i_dir_y,
    input  wire signed [nthd_pkg::CRD_W-1:0]   i_dir_z,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire        [nthd_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_hit,
    output logic       [nthd_pkg::HIDX_W-1:0]  o_hit_index,
    output logic       [nthd_pkg::DIST_W-1:0]  o_hit_distance,
    output logic       [nthd_pkg::DIST_W-1:0]  o_depth_shade
);
    import nthd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    nthd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    nthd_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_data      (i_cfg_data),
        .i_triangle_slot (i_triangle_slot),
        .i_vertex_select (i_vertex_select),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_z       (i_point_z),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .o_hit           (o_hit),
        .o_hit_index     (o_hit_index),
        .o_hit_distance  (o_hit_distance),
        .o_depth_shade   (o_depth_shade)
    );

endmodule
`default_nettype wire

// ===== src/nthd_checker.sv =====
// Port-level checker for the nearest-hit depth core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_triangle_hit_depth_core_defines.svh"
module nthd_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_in_valid,
    input wire                                o_in_stall,
    input wire                                i_req_type,
    input wire        [nthd_pkg::SLOT_W-1:0]  i_triangle_slot,
    input wire        [nthd_pkg::VSEL_W-1:0]  i_vertex_select,
    input wire signed [nthd_pkg::CRD_W-1:0]   i_point_x,
    input wire signed [nthd_pkg::CRD_W-1:0]   i_point_y,
    input wire signed [nthd_pkg::CRD_W-1:0]   i_point_z,
    input wire signed [nthd_pkg::CRD_W-1:0]   i_dir_x,
    input wire signed [nthd_pkg::CRD_W-1:0]   i_dir_y,
    input wire signed [nthd_pkg::CRD_W-1:0]   i_dir_z,
    input wire                                i_cfg_valid,
    input wire                                o_cfg_ready,
    input wire        [nthd_pkg::CFG_W-1:0]   i_cfg_data,
    input wire                                o_out_valid,
    input wire                                i_out_stall,
    input wire                                o_hit,
    input wire        [nthd_pkg::HIDX_W-1:0]  o_hit_index,
    input wire        [nthd_pkg::DIST_W-1:0]  o_hit_distance,
    input wire        [nthd_pkg::DIST_W-1:0]  o_depth_shade
);
    logic [35:0] shade21, dist36;

    assign shade21 = {5'd0, o_depth_shade} * 36'd21;
    assign dist36  = {5'd0, o_hit_distance};

    `NTHD_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `NTHD_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hit) && $stable(o_hit_index) && $stable(o_hit_distance) && $stable(o_depth_shade)), "stalled result changed")
    `NTHD_ASSERT(a_miss_zero, (o_out_valid && !o_hit) |-> (o_hit_index == '0 && o_hit_distance == '0 && o_depth_shade == '0), "miss with nonzero fields")
    `NTHD_ASSERT(a_shade_div, (o_out_valid && o_hit) |-> (shade21 <= dist36 && dist36 < shade21 + 36'd21), "depth shade is not distance/21")
    `NTHD_ASSERT(a_ray_busy, (i_in_valid && !o_in_stall && i_req_type) |=> o_in_stall, "ray accepted without going busy")

endmodule

bind nearest_triangle_hit_depth_core nthd_checker u_nthd_checker (.*);
`default_nettype wire
